FILE: hw/rtl/column_post_patch_renderer_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the column post renderer
// Shared concurrent assertion forms; each expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef COLUMN_POST_PATCH_RENDERER_MACROS_SVH
`define COLUMN_POST_PATCH_RENDERER_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define CPPR_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define CPPR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/cppr_pkg.sv
// ----------------------------------------------------------------------------
// Column post renderer package
// Payload, configuration and queue entry types plus fixed constants.
// ----------------------------------------------------------------------------
package cppr_pkg;

  localparam int ADDR_W      = 19;
  localparam int COORD_W     = 17;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int TABLE_DEPTH = 256;
  localparam int PIXEL_W     = 8;

  localparam logic [7:0] END_MARK = 8'hff;

  localparam logic signed [COORD_W-1:0] COORD_MIN = 17'h10000;
  localparam logic signed [COORD_W-1:0] COORD_MAX = 17'h0ffff;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_DEST_X      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEST_Y      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_OFFSET = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP_OFFSET  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PIC_WIDTH   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FLIP        = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_TRANSLATE   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN      = 3'd7;

  typedef struct packed {
    logic       op;
    logic       column_start;
    logic [9:0] source_column;
    logic [7:0] data_byte;
    logic [7:0] table_index;
  } in_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  pixel_address;
    logic [PIXEL_W-1:0] pixel_value;
    logic               range_error;
  } out_t;

  typedef struct packed {
    logic signed [15:0] dest_x;
    logic signed [15:0] dest_y;
    logic signed [15:0] left_offset;
    logic signed [15:0] top_offset;
    logic [10:0]        picture_width;
    logic               flip_enable;
    logic               translate_enable;
    logic [2:0]         screen_select;
  } cfg_t;

  // One unit of work for the back end: a table load or a pixel write
  typedef struct packed {
    logic                      is_pixel;
    logic signed [COORD_W-1:0] row;
    logic signed [COORD_W-1:0] col;
    logic [7:0]                index;
    logic [7:0]                value;
  } job_t;

endpackage

FILE: hw/rtl/cppr_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module cppr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/cppr_front.sv
// ----------------------------------------------------------------------------
// Column post parser
// Walks the post stream and turns table loads and pixel bytes into jobs.
// ----------------------------------------------------------------------------
`include "column_post_patch_renderer_macros.svh"

module cppr_front (
  input  logic           clk,
  input  logic           rst_n,
  input  cppr_pkg::cfg_t cfg,
  input  logic           in_valid,
  output logic           in_ready,
  input  cppr_pkg::in_t  in_data,
  output logic           push_valid,
  output cppr_pkg::job_t push_job,
  input  logic           push_ready
);

  typedef enum logic [6:0] {
    PH_WAIT  = 7'b0000001,
    PH_DELTA = 7'b0000010,
    PH_LEN   = 7'b0000100,
    PH_PAD   = 7'b0001000,
    PH_PIX   = 7'b0010000,
    PH_TRAIL = 7'b0100000,
    PH_DONE  = 7'b1000000
  } phase_t;

  phase_t                              phase_r, phase_nxt;
  logic signed [cppr_pkg::COORD_W-1:0] row_r, row_nxt;
  logic signed [cppr_pkg::COORD_W-1:0] col_r, col_nxt;
  logic [7:0]                          left_r, left_nxt;

  logic               accept;
  logic signed [18:0] mirror_col;
  logic signed [18:0] col_start;
  logic signed [18:0] row_start;
  logic signed [18:0] row_inc;

  function automatic logic signed [cppr_pkg::COORD_W-1:0] sat17(
    input logic signed [18:0] v
  );
    logic signed [18:0] lo;
    logic signed [18:0] hi;
    lo = 19'(cppr_pkg::COORD_MIN);
    hi = 19'(cppr_pkg::COORD_MAX);
    if (v < lo) begin
      return cppr_pkg::COORD_MIN;
    end else if (v > hi) begin
      return cppr_pkg::COORD_MAX;
    end
    return v[cppr_pkg::COORD_W-1:0];
  endfunction

  assign in_ready = push_ready;
  assign accept   = in_valid && push_ready;

  assign mirror_col = cfg.flip_enable ?
                      ($signed({8'b0, cfg.picture_width}) - 19'sd1 -
                       $signed({9'b0, in_data.source_column})) :
                      $signed({9'b0, in_data.source_column});
  assign col_start  = 19'(cfg.dest_x) - 19'(cfg.left_offset) + mirror_col;
  assign row_start  = 19'(cfg.dest_y) - 19'(cfg.top_offset) +
                      $signed({11'b0, in_data.data_byte});
  assign row_inc    = 19'(row_r) + 19'sd1;

  always_comb begin
    phase_nxt = phase_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    left_nxt  = left_r;

    push_valid        = 1'b0;
    push_job.is_pixel = 1'b1;
    push_job.row      = row_r;
    push_job.col      = col_r;
    push_job.index    = in_data.data_byte;
    push_job.value    = in_data.data_byte;

    if (accept) begin
      if (!in_data.op) begin
        // Table load: pass in order with the pixels around it
        push_valid        = 1'b1;
        push_job.is_pixel = 1'b0;
        push_job.index    = in_data.table_index;
      end else if (in_data.column_start) begin
        col_nxt  = sat17(col_start);
        left_nxt = 8'd0;
        if (in_data.data_byte == cppr_pkg::END_MARK) begin
          phase_nxt = PH_DONE;
        end else begin
          row_nxt   = sat17(row_start);
          phase_nxt = PH_LEN;
        end
      end else begin
        case (phase_r)
          PH_DELTA: begin
            if (in_data.data_byte == cppr_pkg::END_MARK) begin
              phase_nxt = PH_DONE;
            end else begin
              row_nxt   = sat17(row_start);
              phase_nxt = PH_LEN;
            end
          end
          PH_LEN: begin
            left_nxt  = in_data.data_byte;
            phase_nxt = PH_PAD;
          end
          PH_PAD: begin
            phase_nxt = (left_r != 8'd0) ? PH_PIX : PH_TRAIL;
          end
          PH_TRAIL: begin
            phase_nxt = PH_DELTA;
          end
          PH_PIX: begin
            push_valid = 1'b1;
            row_nxt    = sat17(row_inc);
            left_nxt   = left_r - 8'd1;
            if (left_r == 8'd1) begin
              phase_nxt = PH_TRAIL;
            end
          end
          default: begin
            // Waiting for a column start, or column ended: drop the byte
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_WAIT;
      row_r   <= '0;
      col_r   <= '0;
      left_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      left_r  <= left_nxt;
    end
  end

  `CPPR_ASSERT_IMPL(a_pix_has_count, (phase_r == PH_PIX), (left_r != 8'd0), "pixel phase with no pixels left")

endmodule

FILE: hw/rtl/cppr_queue.sv
// ----------------------------------------------------------------------------
// Job queue
// Short FIFO that decouples the parser from the pixel back end.
// ----------------------------------------------------------------------------
`include "column_post_patch_renderer_macros.svh"

module cppr_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  input  cppr_pkg::job_t push_job,
  output logic           push_ready,
  output logic           pop_valid,
  output cppr_pkg::job_t pop_job,
  input  logic           pop
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cppr_pkg::job_t   mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_job    = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_valid) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push_valid && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push_valid) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push_valid) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `CPPR_ASSERT_IMPL(a_no_overflow, push_valid, push_ready, "push into a full queue")
  `CPPR_ASSERT_IMPL(a_no_underflow, pop, pop_valid, "pop from an empty queue")
  `CPPR_ASSERT_NEXT(a_count_up, (push_valid && !pop), (count_r == $past(count_r) + 1'b1), "count did not advance on push")

endmodule

FILE: hw/rtl/cppr_back.sv
// ----------------------------------------------------------------------------
// Pixel back end
// Executes table loads, range-checks pixels and forms framebuffer writes.
// ----------------------------------------------------------------------------
`include "column_post_patch_renderer_macros.svh"

module cppr_back #(
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 200,
  parameter int SCREEN_COUNT  = 6
) (
  input  logic           clk,
  input  logic           rst_n,
  input  cppr_pkg::cfg_t cfg,
  input  logic           pop_valid,
  input  cppr_pkg::job_t pop_job,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output cppr_pkg::out_t out_data
);

  localparam int FRAME  = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int FULL_W = $clog2(SCREEN_COUNT * FRAME);
  localparam int ROW_W  = $clog2(SCREEN_HEIGHT);
  localparam int COL_W  = $clog2(SCREEN_WIDTH);
  localparam int TAB_AW = $clog2(cppr_pkg::TABLE_DEPTH);

  logic [FULL_W-1:0] base_r;
  logic [FULL_W-1:0] addr_a;
  logic              row_ok;
  logic              col_ok;
  logic              scr_ok;
  logic              bad_a;
  logic              advance;
  logic              load_b;
  logic              tab_we;

  logic                            b_valid_r, b_valid_nxt;
  logic [cppr_pkg::ADDR_W-1:0]     b_addr_r;
  logic                            b_err_r;
  logic [cppr_pkg::PIXEL_W-1:0]    b_byte_r;
  logic                            b_trans_r;
  logic [cppr_pkg::PIXEL_W-1:0]    tab_rdata;

  // Screen base only changes with configuration; keep it off the pixel path
  always_ff @(posedge clk) begin
    base_r <= FULL_W'(cfg.screen_select) * FULL_W'(FRAME);
  end

  assign row_ok = (pop_job.row >= 17'sd0) &&
                  (pop_job.row < $signed(17'(SCREEN_HEIGHT)));
  assign col_ok = (pop_job.col >= 17'sd0) &&
                  (pop_job.col < $signed(17'(SCREEN_WIDTH)));
  assign scr_ok = ({1'b0, cfg.screen_select} < 4'(SCREEN_COUNT));
  assign bad_a  = !(row_ok && col_ok && scr_ok);

  assign addr_a = base_r +
                  FULL_W'(pop_job.row[ROW_W-1:0]) * FULL_W'(SCREEN_WIDTH) +
                  FULL_W'(pop_job.col[COL_W-1:0]);

  // Table loads never wait; pixels wait for room in the output stage
  assign advance = !b_valid_r || out_ready;
  assign pop     = pop_valid && (!pop_job.is_pixel || advance);
  assign load_b  = pop && pop_job.is_pixel;
  assign tab_we  = pop && !pop_job.is_pixel;

  cppr_ram #(
    .WIDTH (cppr_pkg::PIXEL_W),
    .DEPTH (cppr_pkg::TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (tab_we),
    .waddr (pop_job.index[TAB_AW-1:0]),
    .wdata (pop_job.value),
    .re    (load_b),
    .raddr (pop_job.index[TAB_AW-1:0]),
    .rdata (tab_rdata)
  );

  always_comb begin
    b_valid_nxt = b_valid_r;
    if (load_b) begin
      b_valid_nxt = 1'b1;
    end else if (out_ready) begin
      b_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else begin
      b_valid_r <= b_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_b) begin
      b_addr_r  <= bad_a ? '0 : cppr_pkg::ADDR_W'(addr_a);
      b_err_r   <= bad_a;
      b_byte_r  <= pop_job.value;
      b_trans_r <= cfg.translate_enable;
    end
  end

  assign out_valid              = b_valid_r;
  assign out_data.pixel_address = b_addr_r;
  assign out_data.pixel_value   = b_trans_r ? tab_rdata : b_byte_r;
  assign out_data.range_error   = b_err_r;

  `CPPR_ASSERT_IMPL(a_err_addr_zero, (out_valid && out_data.range_error), (out_data.pixel_address == '0), "off-screen write with non-zero address")

endmodule

FILE: hw/rtl/column_post_patch_renderer.sv
// Path: a pixel byte goes through the job queue and is registered in the output stage.
// Throughput: one input transaction per cycle while the queue has room, set by the
// one-entry output stage and the single table read port; table loads never wait and make no output.
// Reset: synchronous, active low; clears parse state, queue and output valid and
// loads register defaults. The translation table is not cleared: load before use.

// ----------------------------------------------------------------------------
// Column post renderer, top level
// Configuration registers, post parser, job queue and pixel back end.
// ----------------------------------------------------------------------------
module column_post_patch_renderer #(
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 200,
  parameter int SCREEN_COUNT  = 6,
  parameter int QUEUE_DEPTH   = 4
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [cppr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cppr_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  cppr_pkg::in_t                      in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output cppr_pkg::out_t                     out_data
);

  cppr_pkg::cfg_t cfg_r, cfg_nxt;

  logic           push_valid;
  logic           push_ready;
  cppr_pkg::job_t push_job;
  logic           pop_valid;
  logic           pop;
  cppr_pkg::job_t pop_job;

  // Register file: decode the index and update the one field it names.
  // Writes must arrive only while no transaction is in flight; the block does not enforce
  // this. Stages read these live, but for the screen base, which the back end registers.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        cppr_pkg::CFG_DEST_X:      cfg_nxt.dest_x           = cfg_wdata;
        cppr_pkg::CFG_DEST_Y:      cfg_nxt.dest_y           = cfg_wdata;
        cppr_pkg::CFG_LEFT_OFFSET: cfg_nxt.left_offset      = cfg_wdata;
        cppr_pkg::CFG_TOP_OFFSET:  cfg_nxt.top_offset       = cfg_wdata;
        cppr_pkg::CFG_PIC_WIDTH:   cfg_nxt.picture_width    = cfg_wdata[10:0];
        cppr_pkg::CFG_FLIP:        cfg_nxt.flip_enable      = cfg_wdata[0];
        cppr_pkg::CFG_TRANSLATE:   cfg_nxt.translate_enable = cfg_wdata[0];
        cppr_pkg::CFG_SCREEN:      cfg_nxt.screen_select    = cfg_wdata[2:0];
        default: begin
          // Hold every register
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dest_x           <= '0;
      cfg_r.dest_y           <= '0;
      cfg_r.left_offset      <= '0;
      cfg_r.top_offset       <= '0;
      cfg_r.picture_width    <= 11'd1;
      cfg_r.flip_enable      <= 1'b0;
      cfg_r.translate_enable <= 1'b0;
      cfg_r.screen_select    <= 3'd0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front end: accept every transaction the queue has room for, advance the
  // post parser and emit a job for each table load and each pixel byte.
  cppr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_job   (push_job),
    .push_ready (push_ready)
  );

  // Queue: keep loads and pixels in order so a pixel sees exactly the table
  // entries loaded before it, while the front keeps parsing during output stalls.
  cppr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_job   (push_job),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_job    (pop_job),
    .pop        (pop)
  );

  // Back end: range check, address multiply-add and table lookup, then hold
  // the result in the output stage until it is taken.
  cppr_back #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .SCREEN_COUNT  (SCREEN_COUNT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .pop_valid (pop_valid),
    .pop_job   (pop_job),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
